FILE: hw/rtl/ufr_pkg.sv
// Shared types and constants of the UART frame receiver.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ufr_pkg;

   // Event codes on the input channel.
   localparam logic [1:0] CMD_BYTE    = 2'd0;
   localparam logic [1:0] CMD_TIMEOUT = 2'd1;
   localparam logic [1:0] CMD_ERROR   = 2'd2;
   localparam logic [1:0] CMD_UNUSED  = 2'd3;

   // Result kinds.
   localparam logic [2:0] KIND_BYTE  = 3'd0;
   localparam logic [2:0] KIND_GOOD  = 3'd1;
   localparam logic [2:0] KIND_BAD   = 3'd2;
   localparam logic [2:0] KIND_EMPTY = 3'd3;
   localparam logic [2:0] KIND_LOST  = 3'd4;

   // Configuration register indexes.
   localparam logic [1:0] REG_START_BYTE     = 2'd0;
   localparam logic [1:0] REG_PAYLOAD_LENGTH = 2'd1;
   localparam logic [1:0] REG_TIMEOUT_LIMIT  = 2'd2;
   localparam logic [1:0] REG_EMPTY_LIMIT    = 2'd3;

   // Longest payload a frame may carry.
   localparam logic [7:0] MAX_PAYLOAD = 8'd255;

   // Queue between the front and back parts.
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data_out;
      logic [7:0] byte_index;
   } rsp_type;

   typedef struct packed {
      logic [7:0] start_byte;
      logic [7:0] payload_length;
      logic [7:0] timeout_limit;
      logic [7:0] empty_limit;
   } cfg_type;

   // A classified event as it travels through the queue.
   typedef struct packed {
      logic [1:0] command;
      logic [7:0] rx_byte;
      logic       is_start;
   } op_type;

endpackage

`default_nettype wire

FILE: hw/rtl/ufr_front.sv
// Front part of the UART frame receiver: accepts line events and classifies them.
// Depends on ufr_pkg; feeds ufr_queue.
`timescale 1ns / 1ps
`default_nettype none

module ufr_front (
   input  wire  ufr_pkg::req_type req_data,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire  [7:0]             start_byte,
   input  wire                    queue_full,
   output logic                   push,
   output ufr_pkg::op_type        push_op
);

   logic take;

   assign req_stall = queue_full;
   assign take      = req_valid && !queue_full;

   // The unused event code is taken and dropped here; it has no effect.
   assign push = take && (req_data.command != ufr_pkg::CMD_UNUSED);

   always_comb begin
      push_op.command  = req_data.command;
      push_op.rx_byte  = req_data.rx_byte;
      push_op.is_start = (req_data.rx_byte == start_byte);
   end

endmodule

`default_nettype wire

FILE: hw/rtl/ufr_queue.sv
// Short queue of classified events between the front and back parts.
// Depends on ufr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ufr_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  wire  ufr_pkg::op_type  push_op,
   output logic                   full,
   input  wire                    pop,
   output ufr_pkg::op_type        pop_op,
   output logic                   empty
);

   localparam int unsigned PtrW = ufr_pkg::QUEUE_PTR_W;
   localparam int unsigned CntW = ufr_pkg::QUEUE_CNT_W;
   localparam logic [PtrW-1:0] LastPtr = PtrW'(ufr_pkg::QUEUE_DEPTH - 1);

   ufr_pkg::op_type entry_ff [ufr_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full    = (count_ff == CntW'(ufr_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_op  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/ufr_back.sv
// Back part of the UART frame receiver: frame state machine, link counters and
// the registered result stage. Depends on ufr_pkg; drains ufr_queue.
`timescale 1ns / 1ps
`default_nettype none

module ufr_back (
   input  wire                    clock,
   input  wire                    reset,
   input  wire  ufr_pkg::cfg_type cfg,
   input  wire                    queue_empty,
   input  wire  ufr_pkg::op_type  op,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output ufr_pkg::rsp_type       rsp_data
);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_PAYLOAD,
      PH_CHECK
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [7:0]       byte_count_ff, byte_count_in;
   logic [7:0]       running_sum_ff, running_sum_in;
   logic [7:0]       timeout_count_ff, timeout_count_in;
   logic [7:0]       empty_count_ff, empty_count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ufr_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [7:0] frame_len;
   logic [7:0] count_next;
   logic [8:0] timeout_next;
   logic [8:0] empty_next;
   logic       out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An event is carried out only when the result register can take its result.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = !queue_empty && out_free;

   assign frame_len    = (cfg.payload_length > ufr_pkg::MAX_PAYLOAD) ?
                         ufr_pkg::MAX_PAYLOAD : cfg.payload_length;
   assign count_next   = byte_count_ff + 8'd1;
   assign timeout_next = {1'b0, timeout_count_ff} + 9'd1;
   assign empty_next   = {1'b0, empty_count_ff} + 9'd1;

   always_comb begin
      phase_in         = phase_ff;
      byte_count_in    = byte_count_ff;
      running_sum_in   = running_sum_ff;
      timeout_count_in = timeout_count_ff;
      empty_count_in   = empty_count_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_data_in      = rsp_data_ff;

      if (pop) begin
         rsp_data_in.data_out   = '0;
         rsp_data_in.byte_index = '0;
         case (op.command)
            ufr_pkg::CMD_BYTE: begin
               timeout_count_in = '0;
               empty_count_in   = '0;
               case (phase_ff)
                  PH_PAYLOAD: begin
                     running_sum_in         = running_sum_ff + op.rx_byte;
                     byte_count_in          = count_next;
                     if (count_next >= frame_len) begin
                        phase_in = PH_CHECK;
                     end
                     rsp_valid_in           = 1'b1;
                     rsp_data_in.kind       = ufr_pkg::KIND_BYTE;
                     rsp_data_in.data_out   = op.rx_byte;
                     rsp_data_in.byte_index = byte_count_ff;
                  end
                  PH_CHECK: begin
                     phase_in         = PH_HUNT;
                     byte_count_in    = '0;
                     running_sum_in   = '0;
                     rsp_valid_in     = 1'b1;
                     rsp_data_in.kind = (op.rx_byte == running_sum_ff) ?
                                        ufr_pkg::KIND_GOOD : ufr_pkg::KIND_BAD;
                  end
                  default: begin
                     phase_in = PH_HUNT;
                     if (op.is_start) begin
                        byte_count_in  = '0;
                        running_sum_in = '0;
                        phase_in       = (frame_len == '0) ? PH_CHECK : PH_PAYLOAD;
                     end
                  end
               endcase
            end
            ufr_pkg::CMD_TIMEOUT: begin
               phase_in       = PH_HUNT;
               byte_count_in  = '0;
               running_sum_in = '0;
               rsp_valid_in   = 1'b1;
               if (timeout_next > {1'b0, cfg.timeout_limit}) begin
                  timeout_count_in = '0;
                  empty_count_in   = '0;
                  rsp_data_in.kind = ufr_pkg::KIND_LOST;
               end else begin
                  timeout_count_in = timeout_next[7:0];
                  if (empty_next > {1'b0, cfg.empty_limit}) begin
                     empty_count_in   = '0;
                     rsp_data_in.kind = ufr_pkg::KIND_LOST;
                  end else begin
                     empty_count_in   = empty_next[7:0];
                     rsp_data_in.kind = ufr_pkg::KIND_EMPTY;
                  end
               end
            end
            ufr_pkg::CMD_ERROR: begin
               timeout_count_in = '0;
               empty_count_in   = '0;
               phase_in         = PH_HUNT;
               byte_count_in    = '0;
               running_sum_in   = '0;
               rsp_valid_in     = 1'b1;
               rsp_data_in.kind = ufr_pkg::KIND_LOST;
            end
            default: begin
               // The unused code never reaches the queue.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HUNT;
         byte_count_ff    <= '0;
         running_sum_ff   <= '0;
         timeout_count_ff <= '0;
         empty_count_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         byte_count_ff    <= byte_count_in;
         running_sum_ff   <= running_sum_in;
         timeout_count_ff <= timeout_count_in;
         empty_count_ff   <= empty_count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/uart_frame_receiver.sv
// Top level of the UART frame receiver: configuration registers and the
// front, queue and back parts. Depends on ufr_pkg, ufr_front, ufr_queue, ufr_back.
//
//   Port group  Direction  Handshake           Carries
//   req_        in         req_valid/req_stall  ufr_pkg::req_type (command, rx_byte)
//   rsp_        out        rsp_valid/rsp_stall  ufr_pkg::rsp_type (kind, data_out, byte_index)
//   csr_        in         csr_write_enable     register index and 8-bit data
//
// One event is taken per cycle while req_stall is low; unless it has the unused code, it is
// written into the two-entry queue, and the back part pops it and registers its result, if
// any, in the result register that drives rsp_. The back part carries out one event per cycle,
// bounded by the result register. Reset is synchronous and returns the frame hunt, counters
// and registers to their defaults. A stall on rsp_ fills the queue and then raises req_stall.
`timescale 1ns / 1ps
`default_nettype none

module uart_frame_receiver (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire  ufr_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output ufr_pkg::rsp_type       rsp_data,
   input  wire                    csr_write_enable,
   input  wire  [1:0]             csr_index,
   input  wire  [7:0]             csr_write_data
);

   ufr_pkg::cfg_type cfg_ff, cfg_in;
   ufr_pkg::op_type  push_op;
   ufr_pkg::op_type  pop_op;
   logic             push;
   logic             pop;
   logic             queue_full;
   logic             queue_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            ufr_pkg::REG_START_BYTE:     cfg_in.start_byte     = csr_write_data;
            ufr_pkg::REG_PAYLOAD_LENGTH: cfg_in.payload_length = csr_write_data;
            ufr_pkg::REG_TIMEOUT_LIMIT:  cfg_in.timeout_limit  = csr_write_data;
            ufr_pkg::REG_EMPTY_LIMIT:    cfg_in.empty_limit    = csr_write_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte     <= 8'd0;
         cfg_ff.payload_length <= 8'd8;
         cfg_ff.timeout_limit  <= 8'd10;
         cfg_ff.empty_limit    <= 8'd10;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ufr_front u_front (
      .req_data   (req_data),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .start_byte (cfg_ff.start_byte),
      .queue_full (queue_full),
      .push       (push),
      .push_op    (push_op)
   );

   ufr_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .full    (queue_full),
      .pop     (pop),
      .pop_op  (pop_op),
      .empty   (queue_empty)
   );

   ufr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .op          (pop_op),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

FILE: bench/uart_frame_receiver_test.sv
// Self-checking bench for uart_frame_receiver: it drives line events, predicts every result
// and compares it on arrival, under several register settings.
// Depends on ufr_pkg and the uart_frame_receiver RTL.
`timescale 1ns / 1ps

module uart_frame_receiver_test;

   typedef logic [7:0] byte_q_type[$];

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned SETTLE_CYCLES = 8;

   // Tracks the frame hunt and link counters and holds the results still due.
   class frame_tracker;
      typedef enum logic [1:0] {HUNT, PAYLOAD, CHECKSUM, SPARE} phase_type;

      ufr_pkg::cfg_type cfg;
      phase_type        phase;
      logic [7:0]       count;
      logic [7:0]       sum;
      logic [7:0]       timeouts;
      logic [7:0]       empties;
      ufr_pkg::rsp_type awaited_results[$];
      int unsigned      mismatches;

      function new();
         cfg.start_byte     = 8'd0;
         cfg.payload_length = 8'd8;
         cfg.timeout_limit  = 8'd10;
         cfg.empty_limit    = 8'd10;
         phase      = HUNT;
         count      = '0;
         sum        = '0;
         timeouts   = '0;
         empties    = '0;
         mismatches = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [7:0] val);
         case (idx)
            ufr_pkg::REG_START_BYTE:     cfg.start_byte = val;
            ufr_pkg::REG_PAYLOAD_LENGTH: cfg.payload_length = val;
            ufr_pkg::REG_TIMEOUT_LIMIT:  cfg.timeout_limit = val;
            default:                     cfg.empty_limit = val;
         endcase
      endfunction

      function void clear_frame();
         phase = HUNT;
         count = '0;
         sum   = '0;
      endfunction

      function void take_event(ufr_pkg::req_type ev);
         ufr_pkg::rsp_type r;
         bit               has_result;
         logic [7:0]       frame_len;
         logic [8:0]       t;
         logic [8:0]       e;
         r = '0;
         has_result = 1'b0;
         frame_len = (cfg.payload_length > ufr_pkg::MAX_PAYLOAD) ?
                     ufr_pkg::MAX_PAYLOAD : cfg.payload_length;
         case (ev.command)
            ufr_pkg::CMD_BYTE: begin
               timeouts = '0;
               empties  = '0;
               if (phase == PAYLOAD) begin
                  r.kind       = ufr_pkg::KIND_BYTE;
                  r.data_out   = ev.rx_byte;
                  r.byte_index = count;
                  sum   = sum + ev.rx_byte;
                  count = count + 8'd1;
                  if (count >= frame_len)
                     phase = CHECKSUM;
                  has_result = 1'b1;
               end else if (phase == CHECKSUM) begin
                  r.kind = (ev.rx_byte == sum) ? ufr_pkg::KIND_GOOD : ufr_pkg::KIND_BAD;
                  clear_frame();
                  has_result = 1'b1;
               end else begin
                  phase = HUNT;
                  if (ev.rx_byte == cfg.start_byte) begin
                     count = '0;
                     sum   = '0;
                     // An empty payload goes straight to the checksum byte.
                     phase = (frame_len == 8'd0) ? CHECKSUM : PAYLOAD;
                  end
               end
            end
            ufr_pkg::CMD_TIMEOUT: begin
               clear_frame();
               has_result = 1'b1;
               t = {1'b0, timeouts} + 9'd1;
               if (t > {1'b0, cfg.timeout_limit}) begin
                  timeouts = '0;
                  empties  = '0;
                  r.kind   = ufr_pkg::KIND_LOST;
               end else begin
                  timeouts = t[7:0];
                  e = {1'b0, empties} + 9'd1;
                  if (e > {1'b0, cfg.empty_limit}) begin
                     empties = '0;
                     r.kind  = ufr_pkg::KIND_LOST;
                  end else begin
                     empties = e[7:0];
                     r.kind  = ufr_pkg::KIND_EMPTY;
                  end
               end
            end
            ufr_pkg::CMD_ERROR: begin
               timeouts = '0;
               empties  = '0;
               clear_frame();
               r.kind = ufr_pkg::KIND_LOST;
               has_result = 1'b1;
            end
            default: begin
            end
         endcase
         if (has_result)
            awaited_results.push_back(r);
      endfunction

      function void check_result(ufr_pkg::rsp_type got);
         ufr_pkg::rsp_type want;
         if (awaited_results.size() == 0) begin
            $error("result with none due: kind %0d data_out %0d byte_index %0d",
                   got.kind, got.data_out, got.byte_index);
            mismatches++;
            return;
         end
         want = awaited_results.pop_front();
         if (got.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, got.kind);
            mismatches++;
         end
         if (got.data_out !== want.data_out) begin
            $error("data_out: expected %0d, actual %0d", want.data_out, got.data_out);
            mismatches++;
         end
         if (got.byte_index !== want.byte_index) begin
            $error("byte_index: expected %0d, actual %0d", want.byte_index, got.byte_index);
            mismatches++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   ufr_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   ufr_pkg::rsp_type rsp_data;
   logic             csr_write_enable;
   logic [1:0]       csr_index;
   logic [7:0]       csr_write_data;

   frame_tracker tracker;
   bit           gaps_on;
   int unsigned  sent_count;
   int unsigned  cycle_count;

   uart_frame_receiver u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall = gaps_on && ($urandom_range(99) < 23);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_result(rsp_data);
   end

   function automatic ufr_pkg::req_type make_ev(logic [1:0] cmd, logic [7:0] b);
      ufr_pkg::req_type ev;
      ev.command = cmd;
      ev.rx_byte = b;
      return ev;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_event(ufr_pkg::req_type ev);
      while (gaps_on && $urandom_range(99) < 23) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = ev;
      do
         @(posedge clock);
      while (req_stall);
      tracker.take_event(ev);
      sent_count++;
      @(negedge clock);
   endtask

   // Holds the sender until every due result is in and the pipeline is empty.
   task automatic drain();
      req_valid = 1'b0;
      while (tracker.awaited_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic apply_setting(logic [7:0] sb, logic [7:0] len, logic [7:0] tlim,
                                logic [7:0] elim);
      logic [7:0] vals[4];
      vals = '{sb, len, tlim, elim};
      drain();
      for (int i = 0; i < 4; i++) begin
         csr_write_enable = 1'b1;
         csr_index        = 2'(i);
         csr_write_data   = vals[i];
         tracker.set_reg(2'(i), vals[i]);
         @(negedge clock);
      end
      csr_write_enable = 1'b0;
   endtask

   task automatic send_frame(byte_q_type body, bit corrupt);
      logic [7:0] sum;
      sum = '0;
      send_event(make_ev(ufr_pkg::CMD_BYTE, tracker.cfg.start_byte));
      foreach (body[i]) begin
         send_event(make_ev(ufr_pkg::CMD_BYTE, body[i]));
         sum = sum + body[i];
      end
      if (corrupt)
         sum = sum ^ 8'($urandom_range(1, 255));
      send_event(make_ev(ufr_pkg::CMD_BYTE, sum));
   endtask

   function automatic byte_q_type random_body(int unsigned n);
      byte_q_type body;
      for (int unsigned i = 0; i < n; i++)
         body.push_back(8'($urandom));
      return body;
   endfunction

   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      b = 8'($urandom);
      if (b == tracker.cfg.start_byte)
         b = b ^ 8'h01;
      return b;
   endfunction

   // Mostly whole frames of random content; also noise, cut-off frames, lone events and drains.
   task automatic run_traffic(int unsigned n_items);
      int unsigned stop_at;
      int unsigned pick;
      int unsigned len;
      int unsigned cut;
      stop_at = sent_count + n_items;
      len = tracker.cfg.payload_length;
      while (sent_count < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 62) begin
            repeat ($urandom_range(0, 2))
               send_event(make_ev(ufr_pkg::CMD_BYTE, noise_byte()));
            send_frame(random_body(len), $urandom_range(99) < 20);
         end else if (pick < 70) begin
            cut = (len == 0) ? 0 : $urandom_range(0, len - 1);
            send_event(make_ev(ufr_pkg::CMD_BYTE, tracker.cfg.start_byte));
            repeat (cut) send_event(make_ev(ufr_pkg::CMD_BYTE, 8'($urandom)));
            send_event(make_ev(($urandom_range(1) != 0) ? ufr_pkg::CMD_TIMEOUT :
                               ufr_pkg::CMD_ERROR, 8'($urandom)));
         end else if (pick < 78) begin
            send_event(make_ev(ufr_pkg::CMD_BYTE, 8'($urandom)));
         end else if (pick < 85) begin
            send_event(make_ev(ufr_pkg::CMD_TIMEOUT, 8'($urandom)));
         end else if (pick < 89) begin
            send_event(make_ev(ufr_pkg::CMD_ERROR, 8'($urandom)));
         end else if (pick < 93) begin
            send_event(make_ev(ufr_pkg::CMD_UNUSED, 8'($urandom)));
         end else if (pick < 99) begin
            // Runs of one to nine timeouts, which can trip either limit when that limit is low.
            repeat ($urandom_range(1, 9))
               send_event(make_ev(ufr_pkg::CMD_TIMEOUT, 8'($urandom)));
         end else begin
            drain();
         end
      end
   endtask

   initial begin
      byte_q_type edge_body;
      tracker          = new();
      gaps_on          = 1'b1;
      sent_count       = 0;
      cycle_count      = 0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed items under the reset register values.
      send_event(make_ev(ufr_pkg::CMD_BYTE, 8'h37));
      send_event(make_ev(ufr_pkg::CMD_UNUSED, 8'hFF));
      edge_body = '{8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'hAA, 8'h55};
      send_frame(edge_body, 1'b0);
      send_event(make_ev(ufr_pkg::CMD_BYTE, 8'h00));
      send_event(make_ev(ufr_pkg::CMD_BYTE, 8'hFF));
      send_event(make_ev(ufr_pkg::CMD_BYTE, 8'h00));
      send_event(make_ev(ufr_pkg::CMD_TIMEOUT, 8'h00));
      send_event(make_ev(ufr_pkg::CMD_ERROR, 8'hFF));
      send_frame(random_body(8), 1'b1);

      apply_setting(8'hA5, 8'd4, 8'd3, 8'd5);
      gaps_on = 1'b0;
      run_traffic(300);
      gaps_on = 1'b1;

      apply_setting(8'hFF, 8'd1, 8'd0, 8'd0);
      run_traffic(250);

      // Widest limits: among timeouts, only an unbroken run of 256 reports the link lost.
      apply_setting(8'h00, 8'd0, 8'd255, 8'd255);
      repeat (258) send_event(make_ev(ufr_pkg::CMD_TIMEOUT, 8'($urandom)));
      run_traffic(200);

      apply_setting(8'h7E, 8'd255, 8'd10, 8'd2);
      run_traffic(550);

      repeat (3) begin
         apply_setting(8'($urandom), 8'($urandom_range(1, 16)), 8'($urandom_range(0, 6)),
                       8'($urandom_range(0, 6)));
         run_traffic(100);
      end

      req_valid = 1'b0;
      while (tracker.awaited_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

FILE: uart_frame_receiver.f
hw/rtl/ufr_pkg.sv
hw/rtl/ufr_front.sv
hw/rtl/ufr_queue.sv
hw/rtl/ufr_back.sv
hw/rtl/uart_frame_receiver.sv
bench/uart_frame_receiver_test.sv
